>>> rtl/core/psfp_pkg.sv
// ----------------------------------------------------------------------------
// psfp_pkg
// Shared constants, types and command/status bundles of the frame parser.
// ----------------------------------------------------------------------------
package psfp_pkg;

  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned SUM_BYTES   = 30;
  localparam int unsigned MEAS_WORDS  = 12;
  // first measurement word sits at frame byte 4, i.e. bank row 2
  localparam int unsigned MEAS_ROW0   = 2;

  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES);
  localparam int unsigned ROW_W  = CNT_W - 1;
  localparam int unsigned WIDX_W = 4;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0]        START_RESET  = 8'h42;
  localparam logic [CNT_W-1:0]  CNT_LAST     = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0]  CNT_SUM_END  = CNT_W'(SUM_BYTES);
  localparam logic [WIDX_W-1:0] WIDX_LAST    = WIDX_W'(MEAS_WORDS - 1);
  localparam logic [ROW_W-1:0]  ROW_FIRST    = ROW_W'(MEAS_ROW0);

  // register map (word index into the byte address space)
  localparam logic [0:0] REG_START_BYTE = 1'b0;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_EMIT,
    ST_ERR
  } state_t;

  typedef struct packed {
    logic start;      // start byte accepted, open a frame
    logic collect;    // frame byte accepted
    logic word_clr;   // rewind measurement word counter
    logic rd_issue;   // read next measurement word
    logic err_issue;  // push checksum error result
  } ctl_cmd_t;

  typedef struct packed {
    logic is_start;   // incoming byte equals start byte
    logic cnt_last;   // next frame byte is the final one
    logic sum_match;  // checksum word matches running sum
    logic rd_free;    // read stage can take a request this cycle
    logic word_last;  // word counter at final measurement
  } ctl_sts_t;

endpackage

>>> rtl/core/psfp_if.sv
// ----------------------------------------------------------------------------
// psfp_if
// Valid/ready channel interfaces for received bytes and parsed results.
// ----------------------------------------------------------------------------
interface psfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        frame_ok;
  logic        last;

  modport source (output valid, output word_index, output word_value,
                  output frame_ok, output last, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input frame_ok, input last, output ready);
endinterface

>>> rtl/core/particle_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// particle_sensor_frame_parser
// Hunts for a start byte, collects a 32-byte sensor frame, checks the
// 16-bit sum and emits twelve measurement words or one error result.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  in_rx     | in  | valid/ready            | rx_byte[7:0]
//  out_res   | out | valid/ready            | word_index, word_value,
//            |     |                        | frame_ok, last
//  cfg_*     | in  | APB psel/penable       | start_byte at byte address 0
//
//  One request per cycle is taken while hunting or collecting.  After the
//  final frame byte the sequencer issues twelve frame-store row reads
//  (match) or one error result, one per cycle while the read stage is free,
//  and in_rx is not ready; results leave through a read stage and an output
//  register, so an output stall only holds back further reads.  Synchronous
//  active-low reset returns to hunting with the start byte at 0x42.
// ----------------------------------------------------------------------------
module particle_sensor_frame_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  psfp_in_if.sink                       in_rx,
  psfp_out_if.source                    out_res,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [psfp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [psfp_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [psfp_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import psfp_pkg::*;

  ctl_cmd_t   cmd;
  ctl_sts_t   sts;
  logic [7:0] start_byte;

  // register file: start byte only
  psfp_cfg_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .start_byte (start_byte)
  );

  // sequencer owns in_rx ready and all datapath strobes
  psfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_rx.valid),
    .in_ready (in_rx.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // frame store, checksum and result registers
  psfp_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_byte        (in_rx.rx_byte),
    .start_byte     (start_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_res.valid),
    .out_ready      (out_res.ready),
    .out_word_index (out_res.word_index),
    .out_word_value (out_res.word_value),
    .out_frame_ok   (out_res.frame_ok),
    .out_last       (out_res.last)
  );

endmodule

>>> rtl/core/psfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// psfp_cfg_regs
// APB-style register file holding the start byte.
// ----------------------------------------------------------------------------
module psfp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psfp_pkg::CFG_AW-1:0]   paddr,
  input  logic [psfp_pkg::CFG_DW-1:0]   pwdata,
  output logic [psfp_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output logic [7:0]                    start_byte
);
  import psfp_pkg::*;

  logic [7:0] start_r;
  logic       hit_start;

  assign pready    = 1'b1;
  assign hit_start = (paddr[CFG_AW-1 -: 1] == REG_START_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RESET;
    end else if (psel && penable && pwrite && hit_start) begin
      start_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_start) begin
      prdata = {{(CFG_DW-8){1'b0}}, start_r};
    end
  end

  assign start_byte = start_r;

endmodule

>>> rtl/core/psfp_ctrl.sv
// ----------------------------------------------------------------------------
// psfp_ctrl
// Frame sequencer: hunt, collect, then emit words or an error.
// ----------------------------------------------------------------------------
module psfp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  psfp_pkg::ctl_sts_t  sts,
  output psfp_pkg::ctl_cmd_t  cmd
);
  import psfp_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (acc && sts.is_start) state_nxt = ST_COLLECT;
      end
      ST_COLLECT: begin
        if (acc && sts.cnt_last) state_nxt = sts.sum_match ? ST_EMIT : ST_ERR;
      end
      ST_EMIT: begin
        if (sts.rd_free && sts.word_last) state_nxt = ST_HUNT;
      end
      ST_ERR: begin
        if (sts.rd_free) state_nxt = ST_HUNT;
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_HUNT: begin
        in_ready  = 1'b1;
        cmd.start = acc && sts.is_start;
      end
      ST_COLLECT: begin
        in_ready     = 1'b1;
        cmd.collect  = acc;
        cmd.word_clr = acc && sts.cnt_last;
      end
      ST_EMIT: begin
        cmd.rd_issue = sts.rd_free;
      end
      ST_ERR: begin
        cmd.err_issue = sts.rd_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/psfp_dpath.sv
// ----------------------------------------------------------------------------
// psfp_dpath
// Frame store, byte counter, checksum and the two-stage result path.
// ----------------------------------------------------------------------------
module psfp_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          start_byte,
  input  psfp_pkg::ctl_cmd_t  cmd,
  output psfp_pkg::ctl_sts_t  sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_word_index,
  output logic [15:0]         out_word_value,
  output logic                out_frame_ok,
  output logic                out_last
);
  import psfp_pkg::*;

  localparam int unsigned ROWS = FRAME_BYTES / 2;

  // frame store split into even and odd byte banks, one row per word
  logic [7:0] even_mem [ROWS];
  logic [7:0] odd_mem  [ROWS];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        prev_r;
  logic [WIDX_W-1:0] word_r, word_nxt;

  logic [CNT_W-1:0]  wr_pos;
  logic              wr_en;
  logic [ROW_W-1:0]  rd_row;

  // read stage
  logic              rd_valid_r;
  logic [7:0]        rd_even_r, rd_odd_r;
  logic [WIDX_W-1:0] rd_idx_r;
  logic              rd_ok_r, rd_last_r;

  // output register
  logic              out_valid_r;
  logic [WIDX_W-1:0] out_idx_r;
  logic [15:0]       out_val_r;
  logic              out_ok_r, out_last_r;
  logic              out_load;

  assign wr_en  = cmd.start || cmd.collect;
  assign wr_pos = cmd.start ? '0 : cnt_r;
  assign rd_row = word_r + ROW_FIRST;

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    word_nxt = word_r;
    if (cmd.start) begin
      cnt_nxt = CNT_W'(1);
      sum_nxt = {8'h00, rx_byte};
    end else if (cmd.collect) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r < CNT_SUM_END) sum_nxt = sum_r + {8'h00, rx_byte};
    end
    if (cmd.word_clr) begin
      word_nxt = '0;
    end else if (cmd.rd_issue) begin
      word_nxt = word_r + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      word_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) prev_r <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_pos[0]) even_mem[wr_pos[CNT_W-1:1]] <= rx_byte;
    if (wr_en &&  wr_pos[0]) odd_mem[wr_pos[CNT_W-1:1]]  <= rx_byte;
    if (cmd.rd_issue) begin
      rd_even_r <= even_mem[rd_row];
      rd_odd_r  <= odd_mem[rd_row];
    end
  end

  assign out_load = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.rd_issue || cmd.err_issue) begin
        rd_valid_r <= 1'b1;
      end else if (out_load) begin
        rd_valid_r <= 1'b0;
      end
      if (out_load) out_valid_r <= rd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_idx_r  <= word_r;
      rd_ok_r   <= 1'b1;
      rd_last_r <= (word_r == WIDX_LAST);
    end else if (cmd.err_issue) begin
      rd_idx_r  <= '0;
      rd_ok_r   <= 1'b0;
      rd_last_r <= 1'b1;
    end
    if (out_load && rd_valid_r) begin
      out_idx_r  <= rd_idx_r;
      out_val_r  <= rd_ok_r ? {rd_even_r, rd_odd_r} : 16'h0000;
      out_ok_r   <= rd_ok_r;
      out_last_r <= rd_last_r;
    end
  end

  assign sts.is_start  = (rx_byte == start_byte);
  assign sts.cnt_last  = (cnt_r == CNT_LAST);
  assign sts.sum_match = ({prev_r, rx_byte} == sum_r);
  assign sts.rd_free   = !rd_valid_r || out_load;
  assign sts.word_last = (word_r == WIDX_LAST);

  assign out_valid      = out_valid_r;
  assign out_word_index = out_idx_r;
  assign out_word_value = out_val_r;
  assign out_frame_ok   = out_ok_r;
  assign out_last       = out_last_r;

endmodule

>>> dv/psfp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfp_result_checker
// Snoops the byte, result and register ports, tracks the frame parser's
// state and compares each result against the predicted measurement list.
// ----------------------------------------------------------------------------
module psfp_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  psfp_in_if                            in_mon,
  psfp_out_if                           out_mon,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [psfp_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [psfp_pkg::CFG_DW-1:0]   cfg_pwdata,
  input  logic [psfp_pkg::CFG_DW-1:0]   cfg_prdata,
  input  logic                          cfg_pready,
  output int unsigned                   fail_count,
  output int unsigned                   results_pending,
  output logic                          parser_hunting
);
  import psfp_pkg::*;

  localparam logic [CFG_AW-1:0] START_ADDR = CFG_AW'({REG_START_BYTE, 2'b00});

  typedef struct packed {
    logic [WIDX_W-1:0] idx;
    logic [15:0]       value;
    logic              ok;
    logic              last;
  } meas_result_t;

  logic [7:0]       start_sel;
  logic             collecting;
  logic [CNT_W-1:0] frame_pos;
  logic [15:0]      frame_sum;
  logic [7:0]       frame_buf [FRAME_BYTES];
  meas_result_t     expected_words [$];
  int unsigned      errors;

  assign fail_count = errors;

  initial begin
    errors          = 0;
    results_pending = 0;
    parser_hunting  = 1'b1;
  end

  // one received byte; on the closing byte queue the measurements or the error
  function automatic void parse_byte(input logic [7:0] b);
    meas_result_t r;
    logic [15:0]  sum_word;
    int unsigned  base;
    if (!collecting) begin
      if (b == start_sel) begin
        frame_buf[0] = b;
        frame_sum    = 16'(b);
        frame_pos    = CNT_W'(1);
        collecting   = 1'b1;
      end
      return;
    end
    frame_buf[frame_pos] = b;
    if (frame_pos < CNT_SUM_END)
      frame_sum = frame_sum + 16'(b);
    if (frame_pos != CNT_LAST) begin
      frame_pos = frame_pos + 1'b1;
      return;
    end
    collecting = 1'b0;
    frame_pos  = '0;
    sum_word   = {frame_buf[FRAME_BYTES-2], frame_buf[FRAME_BYTES-1]};
    if (sum_word != frame_sum) begin
      r = '{idx: '0, value: '0, ok: 1'b0, last: 1'b1};
      expected_words.push_back(r);
    end else begin
      for (int k = 0; k < MEAS_WORDS; k++) begin
        base    = 2 * MEAS_ROW0 + 2 * k;
        r.idx   = WIDX_W'(k);
        r.value = {frame_buf[CNT_W'(base)], frame_buf[CNT_W'(base + 1)]};
        r.ok    = 1'b1;
        r.last  = (r.idx == WIDX_LAST);
        expected_words.push_back(r);
      end
    end
    frame_sum = '0;
  endfunction

  function automatic void check_result();
    meas_result_t got;
    meas_result_t want;
    got = {out_mon.word_index, out_mon.word_value, out_mon.frame_ok, out_mon.last};
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result: index %0d value %h ok %b last %b", $time,
               got.idx, got.value, got.ok, got.last);
      errors++;
      return;
    end
    want = expected_words.pop_front();
    if (got !== want) begin
      $display({"%0t: result mismatch: expected index %0d value %h ok %b last %b,",
                " got index %0d value %h ok %b last %b"},
               $time, want.idx, want.value, want.ok, want.last,
               got.idx, got.value, got.ok, got.last);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start_sel  = START_RESET;
      collecting = 1'b0;
      frame_pos  = '0;
      frame_sum  = '0;
      expected_words.delete();
    end else begin
      // results leaving now were caused by earlier bytes
      if (out_mon.valid && out_mon.ready)
        check_result();
      if (in_mon.valid && in_mon.ready)
        parse_byte(in_mon.rx_byte);
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == START_ADDR) begin
        if (cfg_pwrite)
          start_sel = cfg_pwdata[7:0];
        else if (cfg_prdata !== CFG_DW'(start_sel)) begin
          $display("%0t: start byte readback: expected %h, got %h", $time,
                   CFG_DW'(start_sel), cfg_prdata);
          errors++;
        end
      end
    end
    results_pending <= expected_words.size();
    parser_hunting  <= !collecting;
  end

endmodule

>>> dv/tb_particle_sensor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_sensor_frame_parser
// Feeds sensor frames, noise and broken frames to the parser under several
// start-byte settings with random idling and backpressure; the result
// checker predicts and compares, this module decides the verdict.
// ----------------------------------------------------------------------------
module tb_particle_sensor_frame_parser;
  import psfp_pkg::*;

  localparam int unsigned HOLD_CYCLES     = 300;    // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES    = 24;     // emit burst plus margin
  localparam int unsigned IDLE_PCT        = 11;
  localparam int unsigned ITEMS_PER_PHASE = 24;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  localparam logic [CFG_AW-1:0] START_ADDR    = CFG_AW'({REG_START_BYTE, 2'b00});
  // next word slot: no register there, writes must be dropped
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = START_ADDR + CFG_AW'(4);

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_STARTS} fill_t;

  logic clk = 1'b0;
  logic rst_n;

  psfp_in_if  in_ch ();
  psfp_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int unsigned fail_count;
  int unsigned results_pending;
  logic        parser_hunting;

  // knobs shared between the request driver and the result sink
  logic idle_en            = 1'b1;
  logic backpressure_req   = 1'b0;
  logic backpressure_done  = 1'b0;

  logic [7:0]  start_now;            // start byte the block currently hunts for
  logic [7:0]  frame_buf [FRAME_BYTES];
  int unsigned cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  particle_sensor_frame_parser dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_rx       (in_ch),
    .out_res     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  psfp_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .results_pending (results_pending),
    .parser_hunting  (parser_hunting)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result sink: random ready, except for one long hold-off requested by the
  // stimulus while it keeps pushing bytes, so the emit path backs up into the
  // byte input.
  initial begin : result_sink
    int unsigned held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (backpressure_req && !backpressure_done) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES)
          backpressure_done <= 1'b1;
      end else begin
        out_ch.ready <= !idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offer one byte and hold it until taken.  Returns at the accepting edge
  // with valid still high, so a following request goes out back to back.
  task automatic send_byte(input logic [7:0] b);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // same, with a random gap in front of the request
  task automatic send_paced(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    send_byte(b);
  endtask

  // bytes that the hunt drops
  task automatic send_noise(input int unsigned count);
    logic [7:0] b;
    repeat (count) begin
      do b = 8'($urandom_range(0, 255)); while (b == start_now);
      send_paced(b);
    end
  endtask

  // Frame: start byte, 29 body bytes, big-endian 16-bit sum of bytes 0..29.
  // A bad sum flips bits in one of the two checksum bytes.
  function automatic void build_frame(input fill_t fill, input bit bad_sum);
    logic [15:0] sum;
    sum          = 16'(start_now);
    frame_buf[0] = start_now;
    for (int i = 1; i < SUM_BYTES; i++) begin
      case (fill)
        FILL_ZERO:   frame_buf[CNT_W'(i)] = 8'h00;
        FILL_ONES:   frame_buf[CNT_W'(i)] = 8'hFF;
        FILL_STARTS: frame_buf[CNT_W'(i)] = start_now;   // start byte as plain data
        default:     frame_buf[CNT_W'(i)] = 8'($urandom_range(0, 255));
      endcase
      sum = sum + 16'(frame_buf[CNT_W'(i)]);
    end
    frame_buf[FRAME_BYTES-2] = sum[15:8];
    frame_buf[FRAME_BYTES-1] = sum[7:0];
    if (bad_sum)
      frame_buf[CNT_W'(FRAME_BYTES - 1 - $urandom_range(0, 1))] ^=
        8'($urandom_range(1, 255));
  endfunction

  task automatic send_frame_bytes(input int unsigned first, input int unsigned count);
    for (int unsigned i = first; i < first + count; i++)
      send_paced(frame_buf[CNT_W'(i)]);
  endtask

  // Two-phase register access; the register takes the write at the access edge.
  task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (wr && addr == START_ADDR)
      start_now = data[7:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, close any open frame with filler, wait for every result,
  // then let the emit sequencer run dry before touching registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!parser_hunting || results_pending != 0) begin
      if (!parser_hunting) begin
        send_byte(8'($urandom_range(0, 255)));
        in_ch.valid <= 1'b0;
      end
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random body, plus bad sums, truncated
  // frames that pull the next start byte into their body, and line noise.
  // With hold_off the phase keeps offering bytes until the hold-off ends.
  task automatic random_phase(input int unsigned quota, input bit hold_off);
    int unsigned sent;
    int unsigned pick;
    int unsigned count;
    sent = 0;
    while (sent < quota || (hold_off && !backpressure_done)) begin
      if ($urandom_range(0, 99) < 20)
        send_noise($urandom_range(1, 4));
      pick  = $urandom_range(0, 99);
      count = FRAME_BYTES;
      if (pick < 60)
        build_frame(FILL_RANDOM, 1'b0);
      else if (pick < 72)
        build_frame(FILL_RANDOM, 1'b1);
      else if (pick < 84) begin
        build_frame(FILL_RANDOM, 1'b0);
        count = $urandom_range(1, FRAME_BYTES - 1);
      end else
        build_frame(fill_t'($urandom_range(1, 3)), 1'b0);
      send_frame_bytes(0, count);
      sent += count;
      // first frame's results are queued: start the long hold-off now
      if (hold_off && !backpressure_req)
        backpressure_req <= 1'b1;
      if (!(hold_off && !backpressure_done) && $urandom_range(0, 99) < 8)
        settle();
    end
  endtask

  initial begin : stimulus
    logic [7:0] phase_start [4];
    logic [7:0] dropped [4];

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    start_now     = START_RESET;
    phase_start   = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), START_RESET};
    dropped       = '{8'h00, 8'hFF, START_RESET - 8'h01, START_RESET + 8'h01};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // extremes and near misses of the start byte are dropped while hunting
    foreach (dropped[i]) send_paced(dropped[i]);
    build_frame(FILL_ONES, 1'b0);
    send_frame_bytes(0, FRAME_BYTES);
    build_frame(FILL_STARTS, 1'b0);     // no resync on start bytes in the body
    send_frame_bytes(0, FRAME_BYTES);
    build_frame(FILL_RANDOM, 1'b1);     // checksum failure
    send_frame_bytes(0, FRAME_BYTES);

    // start byte changed mid-frame: the open frame completes untouched
    build_frame(FILL_RANDOM, 1'b0);
    send_frame_bytes(0, 10);
    in_ch.valid <= 1'b0;
    // error result of the previous frame leaves before the write
    while (results_pending != 0) @(posedge clk);
    apb_access(1'b1, START_ADDR, CFG_DW'(8'h5A));
    send_frame_bytes(10, FRAME_BYTES - 10);
    send_paced(START_RESET);            // old start byte is noise now
    build_frame(FILL_ZERO, 1'b0);
    send_frame_bytes(0, FRAME_BYTES);

    // write to an unmapped slot must leave the start byte alone
    settle();
    apb_access(1'b1, UNMAPPED_ADDR, CFG_DW'(8'hFF));
    apb_access(1'b0, START_ADDR, '0);
    build_frame(FILL_RANDOM, 1'b0);
    send_frame_bytes(0, FRAME_BYTES);

    // --- random, one phase per start byte setting ---
    for (int p = 0; p < 4; p++) begin
      settle();
      apb_access(1'b1, START_ADDR, CFG_DW'(phase_start[2'(p)]));
      apb_access(1'b0, START_ADDR, '0);
      idle_en <= (p != 2);              // third phase runs flat out
      random_phase(ITEMS_PER_PHASE, p == 0);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
